@@ rtl/core/ypa_pkg.sv @@
// ----------------------------------------------------------------------------
// ypa_pkg
// Shared types, constants and helpers for the YUV picture property adjuster.
// ----------------------------------------------------------------------------
package ypa_pkg;

  localparam int unsigned NumStages = 4;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 10;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_LUMA_GAIN   = 3'd0,
    REG_LUMA_OFFSET = 3'd1,
    REG_HUE_COSINE  = 3'd2,
    REG_HUE_SINE    = 3'd3,
    REG_SATURATION  = 3'd4
  } cfg_reg_t;

  // Per-stage load strobes shared by the luma and chroma datapaths
  typedef struct packed {
    logic [NumStages-1:0] load;
  } stage_ctrl_t;

  localparam logic [16:0] LumaRound  = 17'd64;
  localparam logic signed [15:0] ChromaBias = 16'sd128;

  // Saturate a signed intermediate to an 8-bit sample
  function automatic logic [7:0] clamp8(input logic signed [15:0] x);
    logic [7:0] r;
    if (x < 16'sd0) begin
      r = 8'd0;
    end else if (x > 16'sd255) begin
      r = 8'd255;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/yuv_picture_property_adjust.sv @@
// ----------------------------------------------------------------------------
// yuv_picture_property_adjust
// Brightness, contrast, hue and saturation adjustment of a YUV sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (luma_in, cb_in, cr_in, chroma_valid) enter on in_valid and
//   are taken at a clock edge where in_valid is high and in_stall is low.
//   Each input word gives exactly one output word on out_valid; the receiver
//   holds it with out_stall. A word without chroma yields cb_out/cr_out of 0.
//   Throughput: one word per clock while out_stall is low. The word is
//   loaded into the first of four register stages at the accepting edge
//   and passes through them to the output register (rotation products,
//   rotated sum, saturation products, bias and clamp).
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles close up and a stalled output keeps accepting until the pipe is
//   full; in_stall rises only when all four stages hold words.
//   Reset (rst, synchronous) empties the pipeline and loads unity settings:
//   gain 128, offset 0, cosine 128, sine 0, saturation 64.
//   Configuration is written through wr_en/wr_index/wr_data while idle;
//   indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module yuv_picture_property_adjust (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  wr_en,
  input  logic [ypa_pkg::CfgIndexWidth-1:0]     wr_index,
  input  logic [ypa_pkg::CfgDataWidth-1:0]      wr_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            luma_in,
  input  logic [7:0]                            cb_in,
  input  logic [7:0]                            cr_in,
  input  logic                                  chroma_valid,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            luma_out,
  output logic [7:0]                            cb_out,
  output logic [7:0]                            cr_out,
  output logic                                  chroma_out_valid
);

  localparam int unsigned NS = ypa_pkg::NumStages;

  // Configuration registers
  logic [8:0]        luma_gain;
  logic signed [9:0] luma_offset;
  logic signed [8:0] hue_cosine;
  logic signed [8:0] hue_sine;
  logic [7:0]        saturation;

  // Pipeline control
  logic [NS-1:0]        stage_valid;
  logic [NS-1:0]        stage_ready;
  logic [NS-1:0]        stage_in_valid;
  ypa_pkg::stage_ctrl_t ctrl;

  // Luma path and chroma flag
  logic [16:0]        luma_prod;
  logic [16:0]        luma_rnd;
  logic [9:0]         luma_sh;
  logic signed [15:0] luma_sum;
  logic [7:0]         luma_s2;
  logic [7:0]         luma_s3;
  logic [NS-1:0]      cv;

  // Register writes; unknown indexes fall through untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      luma_gain   <= 9'd128;
      luma_offset <= 10'sd0;
      hue_cosine  <= 9'sd128;
      hue_sine    <= 9'sd0;
      saturation  <= 8'd64;
    end else if (wr_en) begin
      unique case (ypa_pkg::cfg_reg_t'(wr_index))
        ypa_pkg::REG_LUMA_GAIN:   luma_gain   <= wr_data[8:0];
        ypa_pkg::REG_LUMA_OFFSET: luma_offset <= $signed(wr_data[9:0]);
        ypa_pkg::REG_HUE_COSINE:  hue_cosine  <= $signed(wr_data[8:0]);
        ypa_pkg::REG_HUE_SINE:    hue_sine    <= $signed(wr_data[8:0]);
        ypa_pkg::REG_SATURATION:  saturation  <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // A stage may take a new word when it is empty or its word moves on
  always_comb begin
    stage_ready[NS-1] = !stage_valid[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
    stage_in_valid[0] = in_valid;
    for (int k = 1; k < NS; k++) begin
      stage_in_valid[k] = stage_valid[k-1];
    end
    ctrl.load = stage_ready & stage_in_valid;
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (stage_ready[k]) begin
          stage_valid[k] <= stage_in_valid[k];
        end
      end
    end
  end

  assign in_stall  = !stage_ready[0];
  assign out_valid = stage_valid[NS-1];

  // Luma: gain with rounding, shift, offset, clamp
  assign luma_rnd = luma_prod + ypa_pkg::LumaRound;
  assign luma_sh  = luma_rnd[16:7];
  assign luma_sum = $signed({6'd0, luma_sh}) + luma_offset;

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      luma_prod <= 17'(luma_in * luma_gain);
      cv[0]     <= chroma_valid;
    end
    if (ctrl.load[1]) begin
      luma_s2 <= ypa_pkg::clamp8(luma_sum);
      cv[1]   <= cv[0];
    end
    if (ctrl.load[2]) begin
      luma_s3 <= luma_s2;
      cv[2]   <= cv[1];
    end
    if (ctrl.load[3]) begin
      luma_out <= luma_s3;
      cv[3]    <= cv[2];
    end
  end

  assign chroma_out_valid = cv[NS-1];

  ypa_chroma u_chroma (
    .clk         (clk),
    .ctrl        (ctrl),
    .cb_in       (cb_in),
    .cr_in       (cr_in),
    .hue_cosine  (hue_cosine),
    .hue_sine    (hue_sine),
    .saturation  (saturation),
    .chroma_keep (cv[NS-2]),
    .cb_out      (cb_out),
    .cr_out      (cr_out)
  );

`ifndef NO_ASSERTIONS
  // A free receiver means every stage can move, so the input is never held
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  // Input back-pressure only with a full pipeline
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (stage_valid == {NS{1'b1}}))
    else $error("input stalled with an empty stage");

  // Luma-only words carry zero chroma
  a_chroma_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !chroma_out_valid) |-> (cb_out == 8'd0 && cr_out == 8'd0))
    else $error("chroma not cleared for luma-only word");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

@@ rtl/core/ypa_chroma.sv @@
// ----------------------------------------------------------------------------
// ypa_chroma
// Chroma datapath: hue rotation, saturation scaling, re-bias and clamp.
// ----------------------------------------------------------------------------
module ypa_chroma (
  input  logic                     clk,
  input  ypa_pkg::stage_ctrl_t     ctrl,
  input  logic [7:0]               cb_in,
  input  logic [7:0]               cr_in,
  input  logic signed [8:0]        hue_cosine,
  input  logic signed [8:0]        hue_sine,
  input  logic [7:0]               saturation,
  input  logic                     chroma_keep,
  output logic [7:0]               cb_out,
  output logic [7:0]               cr_out
);

  logic signed [8:0]  u;
  logic signed [8:0]  v;
  logic signed [17:0] uc;
  logic signed [17:0] us;
  logic signed [17:0] vc;
  logic signed [17:0] vs;
  logic signed [11:0] u2;
  logic signed [11:0] v2;
  logic signed [20:0] u3;
  logic signed [20:0] v3;
  logic signed [8:0]  sat_s;
  logic signed [10:0] uc_sh;
  logic signed [10:0] us_sh;
  logic signed [10:0] vc_sh;
  logic signed [10:0] vs_sh;
  logic signed [14:0] u3_sh;
  logic signed [14:0] v3_sh;
  logic signed [15:0] cb_b;
  logic signed [15:0] cr_b;

  // centre on zero
  assign u = $signed({1'b0, cb_in}) - 9'sd128;
  assign v = $signed({1'b0, cr_in}) - 9'sd128;

  assign sat_s = $signed({1'b0, saturation});

  // floor shifts are plain arithmetic part-selects
  assign uc_sh = uc[17:7];
  assign us_sh = us[17:7];
  assign vc_sh = vc[17:7];
  assign vs_sh = vs[17:7];
  assign u3_sh = u3[20:6];
  assign v3_sh = v3[20:6];

  assign cb_b = u3_sh + ypa_pkg::ChromaBias;
  assign cr_b = v3_sh + ypa_pkg::ChromaBias;

  // stage 1: rotation products
  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      uc <= u * hue_cosine;
      us <= u * hue_sine;
      vc <= v * hue_cosine;
      vs <= v * hue_sine;
    end
  end

  // stage 2: rotated pair
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      u2 <= uc_sh + vs_sh;
      v2 <= vc_sh - us_sh;
    end
  end

  // stage 3: saturation products
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      u3 <= u2 * sat_s;
      v3 <= v2 * sat_s;
    end
  end

  // stage 4: re-bias, clamp, drop chroma for luma-only words
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      cb_out <= chroma_keep ? ypa_pkg::clamp8(cb_b) : 8'd0;
      cr_out <= chroma_keep ? ypa_pkg::clamp8(cr_b) : 8'd0;
    end
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the YUV brightness/contrast/hue/saturation adjuster.
// A driver process feeds words from a backlog with random gaps, a receiver
// process stalls the output at random, and a monitor predicts every accepted
// word at full precision and compares it with the word that comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // One input word, in port order
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       chroma;
  } pixel_t;

  // One output word, in port order
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       chroma;
  } adjusted_t;

  localparam int unsigned IndexWidth = ypa_pkg::CfgIndexWidth;
  localparam int unsigned DataWidth  = ypa_pkg::CfgDataWidth;

  localparam int LumaShift     = 7;
  localparam int LumaRounding  = 64;
  localparam int HueShift      = 7;
  localparam int SatShift      = 6;
  localparam int ChromaCentre  = 128;
  localparam int SqueezeCycles = 60;
  localparam int RandomPhases  = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  wr_en    = 1'b0;
  logic [IndexWidth-1:0] wr_index = '0;
  logic [DataWidth-1:0]  wr_data  = '0;

  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] luma_in      = '0;
  logic [7:0] cb_in        = '0;
  logic [7:0] cr_in        = '0;
  logic       chroma_valid = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] luma_out;
  logic [7:0] cb_out;
  logic [7:0] cr_out;
  logic       chroma_out_valid;

  // Settings as the block should hold them, starting from the reset values
  int gain_set   = 128;
  int offset_set = 0;
  int cos_set    = 128;
  int sin_set    = 0;
  int sat_set    = 64;

  pixel_t    pixel_backlog[$];
  adjusted_t adjusted_due[$];

  int pixels_queued  = 0;
  int pixels_checked = 0;
  int mismatches     = 0;

  bit in_taken     = 1'b0;
  bit calm         = 1'b0;   // no gaps and no stalls for the whole phase
  bit squeeze_go   = 1'b0;   // set once by the sequencer
  bit squeeze_done = 1'b0;   // owned by the receiver
  int in_gap       = 0;
  int hold_left    = 0;

  yuv_picture_property_adjust uut (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .luma_in          (luma_in),
    .cb_in            (cb_in),
    .cr_in            (cr_in),
    .chroma_valid     (chroma_valid),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .luma_out         (luma_out),
    .cb_out           (cb_out),
    .cr_out           (cr_out),
    .chroma_out_valid (chroma_out_valid)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Saturate to an 8-bit sample
  function automatic logic [7:0] to_sample(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return 8'(x);
  endfunction

  // Expected output word for one input word under the current settings.
  // Shifts of signed ints are arithmetic, so negatives round towards minus
  // infinity as the hardware does.
  function automatic adjusted_t adjust_pixel(input pixel_t px);
    adjusted_t r;
    int        y_scaled;
    int        u;
    int        v;
    int        u_rot;
    int        v_rot;
    y_scaled = (int'(px.luma) * gain_set + LumaRounding) >>> LumaShift;
    r.luma   = to_sample(y_scaled + offset_set);
    r.cb     = '0;
    r.cr     = '0;
    r.chroma = px.chroma;
    if (px.chroma) begin
      u     = int'(px.cb) - ChromaCentre;
      v     = int'(px.cr) - ChromaCentre;
      u_rot = ((u * cos_set) >>> HueShift) + ((v * sin_set) >>> HueShift);
      v_rot = ((v * cos_set) >>> HueShift) - ((u * sin_set) >>> HueShift);
      r.cb  = to_sample(((u_rot * sat_set) >>> SatShift) + ChromaCentre);
      r.cr  = to_sample(((v_rot * sat_set) >>> SatShift) + ChromaCentre);
    end
    return r;
  endfunction

  // Gap or stall length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Sample value biased towards the rails and the chroma centre
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Register value: in the nominal range, at a nominal end, or any raw bits
  function automatic logic [DataWidth-1:0] pick_setting(
      input ypa_pkg::cfg_reg_t idx);
    int lo;
    int hi;
    int roll;
    case (idx)
      ypa_pkg::REG_LUMA_GAIN:   begin lo = 0;    hi = 256; end
      ypa_pkg::REG_LUMA_OFFSET: begin lo = -256; hi = 256; end
      ypa_pkg::REG_SATURATION:  begin lo = 0;    hi = 128; end
      default:                  begin lo = -128; hi = 128; end
    endcase
    roll = $urandom_range(0, 3);
    if (roll == 0) return DataWidth'($urandom_range(0, 1023));
    if (roll == 1) return DataWidth'($urandom_range(0, 1) ? hi : lo);
    return DataWidth'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // Write one register on the port and mirror it in the expected settings
  task automatic write_reg(input logic [IndexWidth-1:0] idx,
                           input logic [DataWidth-1:0] val);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    case (idx)
      ypa_pkg::REG_LUMA_GAIN:   gain_set   = int'(val[8:0]);
      ypa_pkg::REG_LUMA_OFFSET: offset_set = int'($signed(val));
      ypa_pkg::REG_HUE_COSINE:  cos_set    = int'($signed(val[8:0]));
      ypa_pkg::REG_HUE_SINE:    sin_set    = int'($signed(val[8:0]));
      ypa_pkg::REG_SATURATION:  sat_set    = int'(val[7:0]);
      default: ;  // unused index, the block ignores it
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic queue_pixel(input logic [7:0] l, input logic [7:0] b,
                             input logic [7:0] r, input logic cv);
    pixel_backlog.push_back({l, b, r, cv});
    pixels_queued++;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      queue_pixel(pick_sample(), pick_sample(), pick_sample(),
                  $urandom_range(0, 3) != 0);
    end
  endtask

  // Hold until every queued word has come back, then let the pipe drain
  task automatic drain();
    while (pixels_checked != pixels_queued) @(negedge clk);
    repeat (ypa_pkg::NumStages + 2) @(negedge clk);
  endtask

  // Driver: hold a stalled word, otherwise advance to the next one after
  // its gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled word as it is
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (pixel_backlog.size() > 0) begin
      {luma_in, cb_in, cr_in, chroma_valid} <= pixel_backlog.pop_front();
      in_valid <= 1'b1;
      in_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off so that the pipe fills
  // and the block has to stall its input.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (squeeze_go && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left = SqueezeCycles - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict each accepted input word, check each accepted output
  // word against the oldest prediction.
  always @(posedge clk) begin
    adjusted_t want;
    adjusted_t got;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        adjusted_due.push_back(adjust_pixel({luma_in, cb_in, cr_in, chroma_valid}));
      end
      if (out_valid && !out_stall) begin
        got = {luma_out, cb_out, cr_out, chroma_out_valid};
        if (adjusted_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: output word with nothing expected: luma %0d cb %0d cr %0d cv %0b",
                     $time, got.luma, got.cb, got.cr, got.chroma);
          end
        end else begin
          want = adjusted_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"%0t: word %0d: luma %0d/%0d cb %0d/%0d cr %0d/%0d cv %0b/%0b",
                        " (expected/actual)"},
                       $time, pixels_checked, want.luma, got.luma, want.cb, got.cb,
                       want.cr, got.cr, want.chroma, got.chroma);
            end
          end
        end
        pixels_checked++;
      end
    end
  end

  // Sequencer: reset, directed corners, then phases of random words, each
  // under its own settings written while the block is idle.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Unity settings from reset: rails, centre, and words without chroma
    queue_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    queue_pixel(8'd128, 8'd128, 8'd128, 1'b1);
    queue_pixel(8'd0,   8'd255, 8'd0,   1'b1);
    queue_pixel(8'd255, 8'd0,   8'd255, 1'b1);
    queue_pixel(8'd1,   8'd1,   8'd254, 1'b1);
    queue_pixel(8'd254, 8'd127, 8'd129, 1'b1);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd0,   8'd170, 8'd85,  1'b0);
    queue_pixel(8'd170, 8'd85,  8'd170, 1'b1);
    queue_pixel(8'd85,  8'd170, 8'd85,  1'b1);
    queue_pixel(8'd127, 8'd0,   8'd128, 1'b1);
    queue_random(40);
    drain();

    // Low rails of every register; offset, cosine and sine lie beyond the nominal range
    write_reg(ypa_pkg::REG_LUMA_GAIN,   10'd0);
    write_reg(ypa_pkg::REG_LUMA_OFFSET, 10'h200);
    write_reg(ypa_pkg::REG_HUE_COSINE,  10'h100);
    write_reg(ypa_pkg::REG_HUE_SINE,    10'h100);
    write_reg(ypa_pkg::REG_SATURATION,  10'd0);
    queue_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    queue_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    queue_random(45);
    drain();

    // High rails of every register, beyond the nominal range
    write_reg(ypa_pkg::REG_LUMA_GAIN,   10'h1FF);
    write_reg(ypa_pkg::REG_LUMA_OFFSET, 10'h1FF);
    write_reg(ypa_pkg::REG_HUE_COSINE,  10'h0FF);
    write_reg(ypa_pkg::REG_HUE_SINE,    10'h0FF);
    write_reg(ypa_pkg::REG_SATURATION,  10'h0FF);
    queue_pixel(8'd255, 8'd0, 8'd255, 1'b1);
    queue_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    queue_random(45);
    drain();

    // Nominal ends, plus writes to the unused indexes
    write_reg(ypa_pkg::REG_LUMA_GAIN,   10'd256);
    write_reg(ypa_pkg::REG_LUMA_OFFSET, -10'sd256);
    write_reg(ypa_pkg::REG_HUE_COSINE,  -10'sd128);
    write_reg(ypa_pkg::REG_HUE_SINE,    10'd128);
    write_reg(ypa_pkg::REG_SATURATION,  10'd128);
    for (int k = int'(ypa_pkg::REG_SATURATION) + 1; k < (1 << IndexWidth); k++) begin
      write_reg(IndexWidth'(k), DataWidth'($urandom_range(0, 1023)));
    end
    queue_random(45);
    drain();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      for (int k = 0; k <= int'(ypa_pkg::REG_SATURATION); k++) begin
        if ($urandom_range(0, 4) < 3) begin
          write_reg(IndexWidth'(k), pick_setting(ypa_pkg::cfg_reg_t'(k)));
        end
      end
      calm = (phase != 2) && ($urandom_range(0, 3) == 0);
      queue_random($urandom_range(25, 50));
      if (phase == 2) squeeze_go = 1'b1;
      drain();
    end

    if (mismatches == 0 && adjusted_due.size() == 0) begin
      $display("yuv_picture_property_adjust: match");
    end else begin
      $display("yuv_picture_property_adjust: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("yuv_picture_property_adjust: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ypa_pkg.sv
rtl/core/ypa_chroma.sv
rtl/core/yuv_picture_property_adjust.sv
bench/tb.sv
